// ===== hw/rtl/indexed_list_engine_core_assert.svh =====
// Assertion macros for the indexed list engine.
// Used by the top level; relies on its clock and reset ports.
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ILE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed list engine: assertion failed");
// next-cycle implication
`define ILE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed list engine: assertion failed");
`else
`define ILE_ASSERT_NOW(lbl, ante, cons)
`define ILE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/ile_pkg.sv =====
// Shared types and constants of the indexed list engine.
// No dependencies; used by ile_cell and indexed_list_engine_core.
`timescale 1ns / 1ps

package ile_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VAL_W    = 32;
   localparam int OUT_CNT_W = 7;

   // request kinds
   typedef enum logic [2:0] {
      ACT_READ   = 3'd0,
      ACT_FRONT  = 3'd1,
      ACT_END    = 3'd2,
      ACT_AT_POS = 3'd3,
      ACT_DELETE = 3'd4
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // operation broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  pos;
      logic [VAL_W-1:0]  value;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/ile_cell.sv =====
// One list slot: holds a single entry and shifts with its neighbors.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_cell (
   input  logic                         clock,
   input  ile_pkg::cell_cmd_type        cmd,
   input  logic [ile_pkg::IDX_W-1:0]    cell_index,
   input  logic [ile_pkg::VAL_W-1:0]    left_data,
   input  logic [ile_pkg::VAL_W-1:0]    right_data,
   output logic [ile_pkg::VAL_W-1:0]    data_out,
   output logic [ile_pkg::VAL_W-1:0]    read_out
);

   logic [ile_pkg::VAL_W-1:0] data_ff;
   logic [ile_pkg::VAL_W-1:0] data_in;

   // next entry: shift toward the back on insert, toward the front on delete
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         ile_pkg::OP_INSERT: begin
            if (cell_index > cmd.pos) begin
               data_in = left_data;
            end else if (cell_index == cmd.pos) begin
               data_in = cmd.value;
            end
         end
         ile_pkg::OP_DELETE: begin
            if (cell_index >= cmd.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // masked read tap, OR-combined at the top
   assign read_out = (cell_index == cmd.pos) ? data_ff : '0;

endmodule

// ===== hw/rtl/indexed_list_engine_core.sv =====
// Top level of the indexed list engine: request decode, cell row, result register.
// Depends on ile_pkg, ile_cell and indexed_list_engine_core_assert.svh.
//
// Usage:
//   req_* carries one request beat (action, position, value). rsp_* returns
//   exactly one result beat per request (read_value, status, count), in order.
//   The result is registered and presented in the cycle after the accepted request beat.
//   Throughput: one request per cycle while results are taken; the cells at or past
//   the position update in the same cycle as the accepted beat, taking a neighbor's entry or the new value.
//   A read is served from the one-hot OR of the cell read taps.
//   Reset (synchronous, active high) empties the list and drops any pending
//   result; entry contents are not cleared.
//   When rsp_tready is low, the held result stays put and req_tready falls
//   until it is taken; the list is not touched while stalled.
//   Rejected requests (out of range, list full) leave the list unchanged.
`timescale 1ns / 1ps
`include "indexed_list_engine_core_assert.svh"

module indexed_list_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // action[2:0], position[10:3], value[42:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // read_value[31:0], status[33:32], count[40:34]
);

   localparam int CAP = ile_pkg::CAPACITY;

   logic                       req_accept;
   logic [2:0]                 req_action;
   logic [ile_pkg::POS_W-1:0]  req_position;
   logic [ile_pkg::VAL_W-1:0]  req_value;

   logic [ile_pkg::CNT_W-1:0]  cnt_ff;
   logic [ile_pkg::CNT_W-1:0]  cnt_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [ile_pkg::VAL_W-1:0]  rsp_read_ff;
   logic [ile_pkg::VAL_W-1:0]  rsp_read_in;
   ile_pkg::status_type        rsp_status_ff;
   ile_pkg::status_type        rsp_status_in;
   logic [ile_pkg::CNT_W-1:0]  rsp_cnt_ff;

   ile_pkg::cell_cmd_type      cmd;
   logic [ile_pkg::CMP_W-1:0]  pos_cmp;
   logic [ile_pkg::CMP_W-1:0]  cnt_cmp;
   logic                       in_range;
   logic                       ins_range;
   logic                       full;
   logic [ile_pkg::VAL_W-1:0]  read_bus;

   logic [ile_pkg::VAL_W-1:0]  cell_data [CAP];
   logic [ile_pkg::VAL_W-1:0]  cell_read [CAP];

   // input unpack and handshake
   assign req_action   = req_tdata[2:0];
   assign req_position = req_tdata[10:3];
   assign req_value    = req_tdata[42:11];
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_accept   = req_tvalid && req_tready;

   // range and fill checks against the current length
   assign pos_cmp   = ile_pkg::CMP_W'(req_position);
   assign cnt_cmp   = ile_pkg::CMP_W'(cnt_ff);
   assign in_range  = pos_cmp < cnt_cmp;
   assign ins_range = pos_cmp <= cnt_cmp;
   assign full      = (cnt_ff == ile_pkg::CNT_W'(CAP));

   // decode: cell command, status, next length
   always_comb begin
      cmd.op        = ile_pkg::OP_HOLD;
      cmd.pos       = ile_pkg::IDX_W'(req_position);
      cmd.value     = req_value;
      rsp_status_in = ile_pkg::ST_DONE;
      cnt_in        = cnt_ff;
      case (ile_pkg::action_type'(req_action))
         ile_pkg::ACT_READ: begin
            if (!in_range) begin
               rsp_status_in = ile_pkg::ST_RANGE;
            end
         end
         ile_pkg::ACT_FRONT: begin
            if (full) begin
               rsp_status_in = ile_pkg::ST_FULL;
            end else begin
               cmd.op  = ile_pkg::OP_INSERT;
               cmd.pos = '0;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ile_pkg::ACT_END: begin
            if (full) begin
               rsp_status_in = ile_pkg::ST_FULL;
            end else begin
               cmd.op  = ile_pkg::OP_INSERT;
               cmd.pos = ile_pkg::IDX_W'(cnt_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ile_pkg::ACT_AT_POS: begin
            if (!ins_range) begin
               rsp_status_in = ile_pkg::ST_RANGE;
            end else if (full) begin
               rsp_status_in = ile_pkg::ST_FULL;
            end else begin
               cmd.op = ile_pkg::OP_INSERT;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ile_pkg::ACT_DELETE: begin
            if (in_range) begin
               cmd.op = ile_pkg::OP_DELETE;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               rsp_status_in = ile_pkg::ST_RANGE;
            end
         end
         default: begin
            cmd.op = ile_pkg::OP_HOLD;
         end
      endcase
      // the row only moves on an accepted beat
      if (!req_accept) begin
         cmd.op = ile_pkg::OP_HOLD;
         cnt_in = cnt_ff;
      end
   end

   // read data: tap bus on an in-range read, zero otherwise
   assign rsp_read_in =
      ((ile_pkg::action_type'(req_action) == ile_pkg::ACT_READ) && in_range) ? read_bus : '0;

   // row of cells
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [ile_pkg::VAL_W-1:0] left_d;
      logic [ile_pkg::VAL_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      ile_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (ile_pkg::IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .read_out   (cell_read[i])
      );
   end

   // one-hot OR of the read taps
   always_comb begin
      read_bus = '0;
      for (int k = 0; k < CAP; k++) begin
         read_bus = read_bus | cell_read[k];
      end
   end

   // length and result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_read_ff   <= rsp_read_in;
         rsp_status_ff <= rsp_status_in;
         rsp_cnt_ff    <= cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, ile_pkg::OUT_CNT_W'(rsp_cnt_ff), rsp_status_ff, rsp_read_ff};

   // checks
   `ILE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= ile_pkg::CNT_W'(CAP))
   `ILE_ASSERT_NEXT(a_reject_keeps_cnt, req_accept && rsp_status_in != ile_pkg::ST_DONE,
                    $stable(cnt_ff))
   `ILE_ASSERT_NEXT(a_insert_grows, req_accept && cmd.op == ile_pkg::OP_INSERT,
                    cnt_ff == $past(cnt_ff) + 1'b1)
   `ILE_ASSERT_NOW(a_reject_reads_zero,
                   rsp_valid_ff && rsp_status_ff != ile_pkg::ST_DONE, rsp_read_ff == '0)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for indexed_list_engine_core: a shadow list predicts every result beat.
// Depends on ile_pkg and the RTL of indexed_list_engine_core; reads no files.
`timescale 1ns / 1ps

module tb_top;

   // action codes that the engine ignores
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int LONG_STALL  = 80;    // receiver hold-off that backs up the request side
   localparam int BLOCKS      = 13;
   localparam int BLOCK_ITEMS = 150;

   // stimulus shaping modes
   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIXED  = 2;

   typedef struct packed {
      logic [ile_pkg::VAL_W-1:0]     read_value;
      ile_pkg::status_type           status;
      logic [ile_pkg::OUT_CNT_W-1:0] count;
   } list_result_type;

   // Shadow copy of the list; predicts one result per request beat.
   class list_predictor;
      logic [ile_pkg::VAL_W-1:0] entries [ile_pkg::CAPACITY];
      int unsigned               held = 0;
      list_result_type           expected_results [$];
      int unsigned               mismatches = 0;

      function ile_pkg::status_type place(int unsigned at, logic [ile_pkg::VAL_W-1:0] v);
         if (held >= ile_pkg::CAPACITY) return ile_pkg::ST_FULL;
         for (int unsigned i = held; i > at; i--) entries[i] = entries[i-1];
         entries[at] = v;
         held++;
         return ile_pkg::ST_DONE;
      endfunction

      function void note_request(logic [47:0] beat);
         logic [2:0]                act;
         logic [7:0]                pos;
         logic [ile_pkg::VAL_W-1:0] val;
         list_result_type           want;
         act  = beat[2:0];
         pos  = beat[10:3];
         val  = beat[42:11];
         want = '{read_value: '0, status: ile_pkg::ST_DONE, count: '0};
         case (act)
            ile_pkg::ACT_READ: begin
               if (pos < held) want.read_value = entries[pos];
               else want.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::ACT_FRONT: want.status = place(0, val);
            ile_pkg::ACT_END:   want.status = place(held, val);
            ile_pkg::ACT_AT_POS: begin
               // range check wins over the full check
               if (pos > held) want.status = ile_pkg::ST_RANGE;
               else want.status = place(pos, val);
            end
            ile_pkg::ACT_DELETE: begin
               if (pos < held) begin
                  for (int unsigned i = pos; i + 1 < held; i++) entries[i] = entries[i+1];
                  held--;
               end else begin
                  want.status = ile_pkg::ST_RANGE;
               end
            end
            default: ;  // spare codes leave the list alone
         endcase
         want.count = ile_pkg::OUT_CNT_W'(held);
         expected_results.push_back(want);
      endfunction

      function void check_result(logic [47:0] beat);
         list_result_type want;
         list_result_type got;
         got.read_value = beat[31:0];
         got.status     = ile_pkg::status_type'(beat[33:32]);
         got.count      = beat[40:34];
         if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none, actual %h",
                     $time, beat);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, got.read_value);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
         if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // action[2:0], position[10:3], value[42:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // read_value[31:0], status[33:32], count[40:34]

   list_predictor board = new();
   bit            steady_flow = 1'b0;  // both sides run without gaps
   bit            long_stall_request = 1'b0;
   int            idle_cycles = 0;

   indexed_list_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: random gaps per beat, plus one long hold-off on request
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 5);
         if (long_stall_request) begin
            gap = LONG_STALL;
            long_stall_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offer one request beat after a random gap; returns at the accepting edge
   task automatic send_request(input logic [2:0] act, input logic [7:0] pos,
                               input logic [ile_pkg::VAL_W-1:0] val);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, pos, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [ile_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 31))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly in-range positions; now and then anything from top up to 255
   function automatic logic [7:0] pick_position(int unsigned top);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(top, 255));
      return 8'($urandom_range(0, top));
   endfunction

   initial begin
      int          mode;
      int          roll;
      int unsigned held_now;
      logic [2:0]  act;
      logic [7:0]  pos;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, every insert flavor, value extremes, edges of the range
      send_request(ile_pkg::ACT_READ,   8'd0,   32'h0);
      send_request(ile_pkg::ACT_READ,   8'd255, 32'h0);
      send_request(ile_pkg::ACT_DELETE, 8'd0,   32'h0);
      send_request(ile_pkg::ACT_AT_POS, 8'd1,   32'h1111_1111);
      send_request(ile_pkg::ACT_AT_POS, 8'd0,   32'h7FFF_FFFF);
      send_request(ile_pkg::ACT_FRONT,  8'd200, 32'h8000_0000);
      send_request(ile_pkg::ACT_END,    8'd0,   32'hFFFF_FFFF);
      send_request(ile_pkg::ACT_END,    8'd0,   32'h0000_0000);
      send_request(ile_pkg::ACT_AT_POS, 8'd4,   32'h1234_5678);  // position equal to length appends
      send_request(ile_pkg::ACT_AT_POS, 8'd2,   32'hA5A5_A5A5);
      send_request(ile_pkg::ACT_READ,   8'd0,   32'hFFFF_FFFF);
      send_request(ile_pkg::ACT_READ,   8'd5,   32'h0);
      send_request(ile_pkg::ACT_READ,   8'd6,   32'h0);
      send_request(ile_pkg::ACT_READ,   8'd255, 32'h0);
      send_request(ile_pkg::ACT_DELETE, 8'd6,   32'h0);
      send_request(ile_pkg::ACT_DELETE, 8'd5,   32'h0);
      send_request(ile_pkg::ACT_DELETE, 8'd0,   32'h0);
      send_request(ile_pkg::ACT_DELETE, 8'd2,   32'h0);
      send_request(ACT_SPARE_5, 8'd0,   32'h0);
      send_request(ACT_SPARE_6, 8'd1,   32'h5A5A_5A5A);
      send_request(ACT_SPARE_7, 8'd255, 32'hFFFF_FFFF);
      send_request(ile_pkg::ACT_AT_POS, 8'd255, 32'h0F0F_0F0F);
      send_request(ile_pkg::ACT_READ,   8'd1,   32'h0);

      // Random: grow to full, drain to empty, and churn in between
      for (int blk = 0; blk < BLOCKS; blk++) begin
         mode        = (blk % 3 == 0) ? MODE_GROW : (blk % 3 == 1) ? MODE_SHRINK : MODE_MIXED;
         steady_flow = ($urandom_range(0, 3) == 0);
         if (blk == 2) long_stall_request = 1'b1;
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            held_now = board.held;
            roll     = $urandom_range(0, 99);
            if (roll < 5) begin
               // noise: any action code, any position
               act = 3'($urandom_range(0, 7));
               pos = 8'($urandom_range(0, 255));
            end else begin
               roll = $urandom_range(0, 99);
               case (mode)
                  MODE_GROW:
                     act = (roll < 75) ? ile_pkg::ACT_FRONT :
                           (roll < 85) ? ile_pkg::ACT_DELETE : ile_pkg::ACT_READ;
                  MODE_SHRINK:
                     act = (roll < 70) ? ile_pkg::ACT_DELETE :
                           (roll < 85) ? ile_pkg::ACT_READ : ile_pkg::ACT_FRONT;
                  default:
                     act = (roll < 35) ? ile_pkg::ACT_FRONT :
                           (roll < 70) ? ile_pkg::ACT_DELETE : ile_pkg::ACT_READ;
               endcase
               // spread inserts over the three flavors
               if (act == ile_pkg::ACT_FRONT) begin
                  case ($urandom_range(0, 2))
                     0:       act = ile_pkg::ACT_FRONT;
                     1:       act = ile_pkg::ACT_END;
                     default: act = ile_pkg::ACT_AT_POS;
                  endcase
               end
               if (act == ile_pkg::ACT_AT_POS) pos = pick_position(held_now);
               else if (act == ile_pkg::ACT_END || act == ile_pkg::ACT_FRONT)
                  pos = 8'($urandom_range(0, 255));
               else pos = pick_position((held_now > 0) ? held_now - 1 : 0);
            end
            send_request(act, pos, pick_value());
         end
      end
      req_tvalid <= 1'b0;
      steady_flow = 1'b0;

      // Drain, then let the registered result stage settle before the final check
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.mismatches == 0 && board.expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
